@@ sv/efg_pkg.sv @@
// ----------------------------------------------------------------------------
// efg_pkg
// Shared types, codes and default sizes for the event flag group.
// ----------------------------------------------------------------------------
package efg_pkg;

    localparam int WAIT_DEPTH_DEF     = 16;
    localparam int FLAG_BITS_DEF      = 32;
    localparam int THREAD_ID_BITS_DEF = 8;

    // request kind
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    // flag combine option
    localparam logic [1:0] OPT_AND = 2'd0;
    localparam logic [1:0] OPT_OR  = 2'd1;

    typedef enum logic [2:0] {
        STATUS_SUCCESS = 3'd0,
        STATUS_FAILED  = 3'd1,
        STATUS_INVALID = 3'd2,
        STATUS_QUEUED  = 3'd3,
        STATUS_FULL    = 3'd4
    } status_t;

    // sequencer -> waiter queue
    typedef struct packed {
        logic push;
        logic pop;
    } waitq_ctl_t;

    // waiter queue -> sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } waitq_sts_t;

endpackage

@@ sv/efg_req_if.sv @@
// ----------------------------------------------------------------------------
// efg_req_if
// Request channel: get / set beats with valid-ready handshake.
// ----------------------------------------------------------------------------
interface efg_req_if #(
    parameter int FLAG_BITS      = efg_pkg::FLAG_BITS_DEF,
    parameter int THREAD_ID_BITS = efg_pkg::THREAD_ID_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [FLAG_BITS-1:0]      mask;
    logic [1:0]                option;
    logic                      wait_req;
    logic [THREAD_ID_BITS-1:0] thread_id;

    modport source (
        output valid, kind, mask, option, wait_req, thread_id,
        input  ready
    );

    modport sink (
        input  valid, kind, mask, option, wait_req, thread_id,
        output ready
    );
endinterface

@@ sv/efg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// efg_rsp_if
// Response channel: one beat per result, valid-ready handshake.
// ----------------------------------------------------------------------------
interface efg_rsp_if #(
    parameter int FLAG_BITS      = efg_pkg::FLAG_BITS_DEF,
    parameter int THREAD_ID_BITS = efg_pkg::THREAD_ID_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [FLAG_BITS-1:0]      actual_flags;
    logic                      woken_valid;
    logic [THREAD_ID_BITS-1:0] woken_thread;
    logic                      last;

    modport source (
        output valid, status, actual_flags, woken_valid, woken_thread, last,
        input  ready
    );

    modport sink (
        input  valid, status, actual_flags, woken_valid, woken_thread, last,
        output ready
    );
endinterface

@@ sv/efg_flag_unit.sv @@
// ----------------------------------------------------------------------------
// efg_flag_unit
// Flag word test (all / any of the mask) and set update (AND / OR).
// ----------------------------------------------------------------------------
module efg_flag_unit #(
    parameter int FLAG_BITS = efg_pkg::FLAG_BITS_DEF
) (
    input  logic [FLAG_BITS-1:0] flags,
    input  logic [FLAG_BITS-1:0] mask,
    input  logic                 is_or,
    output logic                 pass,
    output logic [FLAG_BITS-1:0] flags_upd
);

    logic [FLAG_BITS-1:0] hit;

    assign hit       = flags & mask;
    // empty mask: AND passes, OR misses
    assign pass      = is_or ? (|hit) : (hit == mask);
    assign flags_upd = is_or ? (flags | mask) : hit;

endmodule

@@ sv/efg_waitq.sv @@
// ----------------------------------------------------------------------------
// efg_waitq
// Circular FIFO of waiting thread IDs with a registered read port.
// ----------------------------------------------------------------------------
module efg_waitq #(
    parameter int DEPTH   = efg_pkg::WAIT_DEPTH_DEF,
    parameter int ID_BITS = efg_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  efg_pkg::waitq_ctl_t ctl,
    input  logic [ID_BITS-1:0]  push_id,
    output logic [ID_BITS-1:0]  pop_id,
    output efg_pkg::waitq_sts_t sts
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail;
    logic [ID_BITS-1:0] pop_id_reg;

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                              : PTR_W'(tail_sum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail] <= push_id;
        end
        if (ctl.pop)
        begin
            pop_id_reg <= mem[head_reg];
        end
    end

    assign pop_id    = pop_id_reg;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == DEPTH_CNT);

endmodule

@@ sv/event_flag_group.sv @@
// ----------------------------------------------------------------------------
// event_flag_group
// Event flag group: flag word plus FIFO of threads waiting on it.
// ----------------------------------------------------------------------------
//  channel | modport | beat
//  --------+---------+--------------------------------------------------
//  req     | sink    | kind, mask, option, wait_req, thread_id
//  rsp     | source  | status, actual_flags, woken_valid, woken_thread, last
//
//  A get or an invalid request: one rsp beat the next cycle after it is accepted.
//  A set: one rsp beat per queued waiter, one beat per cycle out of the queue
//  read port while rsp.ready is high (one beat when the queue is empty).
//  req.ready is high only while no rsp beat is pending.
//  Reset clears the flag word and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module event_flag_group #(
    parameter int WAIT_DEPTH     = efg_pkg::WAIT_DEPTH_DEF,
    parameter int FLAG_BITS      = efg_pkg::FLAG_BITS_DEF,
    parameter int THREAD_ID_BITS = efg_pkg::THREAD_ID_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    efg_req_if.sink   req,
    efg_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [FLAG_BITS-1:0] flag_reg, flag_next;
    efg_pkg::status_t     status_reg, status_next;
    logic                 woken_reg, woken_next;

    efg_pkg::waitq_ctl_t     q_ctl;
    efg_pkg::waitq_sts_t     q_sts;
    logic [THREAD_ID_BITS-1:0] q_pop_id;

    logic                 req_fire, rsp_fire;
    logic                 opt_ok, is_or, pass;
    logic [FLAG_BITS-1:0] flags_upd;

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = rsp.valid && rsp.ready;
    assign is_or    = (req.option == efg_pkg::OPT_OR);

    always_comb
    begin
        unique case (req.option) inside
            efg_pkg::OPT_AND, efg_pkg::OPT_OR: opt_ok = 1'b1;
            default:                           opt_ok = 1'b0;
        endcase
    end

    efg_flag_unit #(
        .FLAG_BITS (FLAG_BITS)
    ) u_flag (
        .flags     (flag_reg),
        .mask      (req.mask),
        .is_or     (is_or),
        .pass      (pass),
        .flags_upd (flags_upd)
    );

    efg_waitq #(
        .DEPTH   (WAIT_DEPTH),
        .ID_BITS (THREAD_ID_BITS)
    ) u_waitq (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (q_ctl),
        .push_id (req.thread_id),
        .pop_id  (q_pop_id),
        .sts     (q_sts)
    );

    always_comb
    begin
        state_next  = state_reg;
        flag_next   = flag_reg;
        status_next = status_reg;
        woken_next  = woken_reg;
        q_ctl       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_OUT;
                    woken_next = 1'b0;
                    if (!opt_ok)
                    begin
                        status_next = efg_pkg::STATUS_INVALID;
                    end
                    else if (req.kind == efg_pkg::KIND_GET)
                    begin
                        if (pass)
                        begin
                            status_next = efg_pkg::STATUS_SUCCESS;
                        end
                        else if (!req.wait_req)
                        begin
                            status_next = efg_pkg::STATUS_FAILED;
                        end
                        else if (q_sts.full)
                        begin
                            status_next = efg_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            status_next = efg_pkg::STATUS_QUEUED;
                            q_ctl.push  = 1'b1;
                        end
                    end
                    else
                    begin
                        flag_next   = flags_upd;
                        status_next = efg_pkg::STATUS_SUCCESS;
                        if (!q_sts.empty)
                        begin
                            // first waiter read now, shows up with the beat
                            q_ctl.pop  = 1'b1;
                            woken_next = 1'b1;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (rsp_fire)
                begin
                    if (woken_reg && !q_sts.empty)
                    begin
                        q_ctl.pop = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            flag_reg   <= '0;
            status_reg <= efg_pkg::STATUS_SUCCESS;
            woken_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            flag_reg   <= flag_next;
            status_reg <= status_next;
            woken_reg  <= woken_next;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_OUT);
    assign rsp.status       = status_reg;
    assign rsp.actual_flags = flag_reg;
    assign rsp.woken_valid  = woken_reg;
    assign rsp.woken_thread = woken_reg ? q_pop_id : '0;
    assign rsp.last         = !woken_reg || q_sts.empty;

    // more waiters pending: the next beat follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_fire && !rsp.last) |=> rsp.valid)
        else $error("drain stopped before last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request taken while a beat is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.kind == efg_pkg::KIND_GET) |=> (!rsp.woken_valid && rsp.last))
        else $error("get produced a wake beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !opt_ok) |=> ($stable(flag_reg) &&
                                   rsp.status == efg_pkg::STATUS_INVALID))
        else $error("invalid option changed state");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_ctl.push && q_ctl.pop))
        else $error("queue push and pop in one cycle");

endmodule
